[src/mtfp_pkg.sv]
// Shared types, codes and helpers for the Modbus TCP frame parser.
package mtfp_pkg;

  localparam int HdrBytes = 7;
  localparam int WinAw = 3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PROTO_ID  = 3'd1;
  localparam logic [2:0] ERR_LENGTH    = 3'd2;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
  localparam logic [2:0] ERR_VALIDATE  = 3'd4;
  localparam logic [2:0] ERR_STUCK     = 3'd5;

  localparam logic [1:0] REG_RECOVERY  = 2'd0;
  localparam logic [1:0] REG_STRICT    = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME = 2'd2;

  localparam logic       RECOVERY_RESET  = 1'b1;
  localparam logic       STRICT_RESET    = 1'b1;
  localparam logic [8:0] MAX_FRAME_RESET = 9'd261;

  localparam logic       OP_BYTE  = 1'b0;
  localparam logic       OP_RESET = 1'b1;

  localparam logic [7:0] MAX_UNIT_ID = 8'd247;
  localparam logic [7:0] MIN_LEN     = 8'd2;
  localparam logic [8:0] MBAP_PREFIX = 9'd6;

  typedef enum logic [4:0] {
    ST_HDR  = 5'b00001,
    ST_FC   = 5'b00010,
    ST_BODY = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_ERR  = 5'b10000
  } state_t;

  typedef struct packed {
    logic       recovery_enable;
    logic       strict_check;
    logic [8:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [7:0]  data_count;
    logic [7:0]  out_byte;
    logic        last;
  } res_t;

  function automatic logic fc_allowed(input logic [7:0] fc);
    logic [6:0] f;
    logic       ok;
    f = fc[6:0];
    case (f) inside
      7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd15, 7'd16: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[src/mtfp_cfg.sv]
// Configuration register file for the Modbus TCP frame parser.
module mtfp_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data,
  output mtfp_pkg::cfg_t   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recovery_enable <= mtfp_pkg::RECOVERY_RESET;
      cfg.strict_check    <= mtfp_pkg::STRICT_RESET;
      cfg.max_frame_bytes <= mtfp_pkg::MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mtfp_pkg::REG_RECOVERY:  cfg.recovery_enable <= cfg_data[0];
        mtfp_pkg::REG_STRICT:    cfg.strict_check    <= cfg_data[0];
        mtfp_pkg::REG_MAX_FRAME: cfg.max_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[src/mtfp_core.sv]
// Header window, parse state and per-byte result logic.
module mtfp_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           opcode,
  input  logic [7:0]     in_byte,
  input  mtfp_pkg::cfg_t cfg,
  output logic           res_valid,
  output mtfp_pkg::res_t res
);

  mtfp_pkg::state_t state, state_next;
  logic [mtfp_pkg::WinAw-1:0] fill, fill_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] hdr [mtfp_pkg::HdrBytes];
  logic [7:0] hdr_next [mtfp_pkg::HdrBytes];
  logic [7:0] fc, fc_next;

  logic [7:0] count;
  logic [8:0] frame_size;
  logic [2:0] hdr_code;
  logic       fc_bad;

  assign count      = hdr[5] - mtfp_pkg::MIN_LEN;
  assign frame_size = {1'b0, hdr[5]} + mtfp_pkg::MBAP_PREFIX;
  assign fc_bad     = cfg.strict_check &&
                      (!mtfp_pkg::fc_allowed(in_byte) || hdr[6] > mtfp_pkg::MAX_UNIT_ID);

  always_comb begin
    if (hdr[2] != 8'd0 || hdr[3] != 8'd0) begin
      hdr_code = mtfp_pkg::ERR_PROTO_ID;
    end else if (hdr[4] != 8'd0 || hdr[5] < mtfp_pkg::MIN_LEN) begin
      hdr_code = mtfp_pkg::ERR_LENGTH;
    end else if (frame_size > cfg.max_frame_bytes) begin
      hdr_code = mtfp_pkg::ERR_TOO_LARGE;
    end else begin
      hdr_code = mtfp_pkg::ERR_NONE;
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    remaining_next = remaining;
    hdr_next       = hdr;
    fc_next        = fc;
    res_valid      = 1'b0;
    res            = '0;
    if (opcode == mtfp_pkg::OP_RESET) begin
      state_next     = mtfp_pkg::ST_HDR;
      fill_next      = '0;
      remaining_next = '0;
    end else begin
      unique case (state)
        mtfp_pkg::ST_ERR: begin
          res_valid      = 1'b1;
          res.kind       = mtfp_pkg::KIND_ERROR;
          res.error_code = mtfp_pkg::ERR_STUCK;
        end
        mtfp_pkg::ST_SKIP: begin
          remaining_next = remaining - 8'd1;
          if (remaining == 8'd1) begin
            state_next = mtfp_pkg::ST_HDR;
            fill_next  = '0;
          end
        end
        mtfp_pkg::ST_FC: begin
          fc_next = in_byte;
          if (fc_bad) begin
            if (cfg.recovery_enable) begin
              if (count == 8'd0) begin
                state_next = mtfp_pkg::ST_HDR;
                fill_next  = '0;
              end else begin
                state_next     = mtfp_pkg::ST_SKIP;
                remaining_next = count;
              end
            end else begin
              state_next     = mtfp_pkg::ST_ERR;
              res_valid      = 1'b1;
              res.kind       = mtfp_pkg::KIND_ERROR;
              res.error_code = mtfp_pkg::ERR_VALIDATE;
            end
          end else begin
            res_valid      = 1'b1;
            res.kind       = mtfp_pkg::KIND_START;
            res.trans_id   = {hdr[0], hdr[1]};
            res.unit_id    = hdr[6];
            res.func_code  = in_byte;
            res.data_count = count;
            if (count == 8'd0) begin
              res.last   = 1'b1;
              state_next = mtfp_pkg::ST_HDR;
              fill_next  = '0;
            end else begin
              state_next     = mtfp_pkg::ST_BODY;
              remaining_next = count;
            end
          end
        end
        mtfp_pkg::ST_BODY: begin
          res_valid      = 1'b1;
          res.kind       = mtfp_pkg::KIND_DATA;
          res.trans_id   = {hdr[0], hdr[1]};
          res.unit_id    = hdr[6];
          res.func_code  = fc;
          res.data_count = count;
          res.out_byte   = in_byte;
          remaining_next = remaining - 8'd1;
          if (remaining == 8'd1) begin
            res.last   = 1'b1;
            state_next = mtfp_pkg::ST_HDR;
            fill_next  = '0;
          end
        end
        mtfp_pkg::ST_HDR: begin
          if (fill != mtfp_pkg::WinAw'(mtfp_pkg::HdrBytes - 1)) begin
            hdr_next[fill] = in_byte;
            fill_next      = fill + mtfp_pkg::WinAw'(1);
          end else if (hdr_code != mtfp_pkg::ERR_NONE) begin
            if (cfg.recovery_enable) begin
              for (int i = 0; i < mtfp_pkg::HdrBytes - 2; i++) begin
                hdr_next[i] = hdr[i+1];
              end
              hdr_next[mtfp_pkg::HdrBytes-2] = in_byte;
            end else begin
              state_next     = mtfp_pkg::ST_ERR;
              res_valid      = 1'b1;
              res.kind       = mtfp_pkg::KIND_ERROR;
              res.error_code = hdr_code;
            end
          end else begin
            hdr_next[mtfp_pkg::HdrBytes-1] = in_byte;
            state_next = mtfp_pkg::ST_FC;
          end
        end
        default: begin
          state_next = mtfp_pkg::ST_HDR;
          fill_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtfp_pkg::ST_HDR;
      fill      <= '0;
      remaining <= '0;
    end else if (accept) begin
      state     <= state_next;
      fill      <= fill_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= hdr_next;
      fc  <= fc_next;
    end
  end

endmodule

[src/mtfp_out_reg.sv]
// Result register between the parse logic and the output channel.
module mtfp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mtfp_pkg::res_t res,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output mtfp_pkg::res_t out_res
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      out_res <= res;
    end
  end

endmodule

[src/modbus_tcp_frame_parser.sv]
// Top level of the Modbus TCP MBAP deframer.
// One stream byte is taken per cycle while in_stall is low and its result,
// if any, appears in the result register on the next cycle; the header
// check, function code check and data byte forwarding each finish in the
// cycle of the byte that completes them. in_stall is high only while the
// result register holds a result that the output side is stalling, so
// throughput is one byte per cycle whenever out_stall is low.
// Configuration writes are taken every cycle (cfg_ready is always high).
module modbus_tcp_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  error_code,
  output logic [15:0] trans_id,
  output logic [7:0]  unit_id,
  output logic [7:0]  func_code,
  output logic [7:0]  data_count,
  output logic [7:0]  out_byte,
  output logic        last
);

  mtfp_pkg::cfg_t cfg;
  mtfp_pkg::res_t res;
  mtfp_pkg::res_t out_res;
  logic           res_valid;
  logic           room;
  logic           accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  mtfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .in_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mtfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind       = out_res.kind;
  assign error_code = out_res.error_code;
  assign trans_id   = out_res.trans_id;
  assign unit_id    = out_res.unit_id;
  assign func_code  = out_res.func_code;
  assign data_count = out_res.data_count;
  assign out_byte   = out_res.out_byte;
  assign last       = out_res.last;

endmodule

[src/mtfp_checker.sv]
// Port-level checks for the Modbus TCP frame parser, bound to the top level.
module mtfp_assert (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [2:0]  error_code,
  input logic [7:0]  out_byte,
  input logic        last
);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with result register free");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

  a_error_code_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == mtfp_pkg::KIND_ERROR) ==
                   (error_code != mtfp_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == mtfp_pkg::KIND_ERROR) |->
      (out_byte == 8'd0 && !last && error_code <= mtfp_pkg::ERR_STUCK))
    else $error("error report carries packet fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(out_byte)))
    else $error("stalled result changed");

endmodule

bind modbus_tcp_frame_parser mtfp_assert u_mtfp_assert (
  .clk        (clk),
  .rst        (rst),
  .cfg_ready  (cfg_ready),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .error_code (error_code),
  .out_byte   (out_byte),
  .last       (last)
);
